// ===== design/bfle_pkg.sv =====
package bfle_pkg;

  // Request codes
  localparam logic [3:0] REQ_BEGIN_DOC  = 4'd0;
  localparam logic [3:0] REQ_END_DOC    = 4'd1;
  localparam logic [3:0] REQ_BEGIN_NODE = 4'd2;
  localparam logic [3:0] REQ_END_NODE   = 4'd3;
  localparam logic [3:0] REQ_WORD       = 4'd4;
  localparam logic [3:0] REQ_SPACE      = 4'd5;
  localparam logic [3:0] REQ_NEWLINE    = 4'd6;
  localparam logic [3:0] REQ_BREAK      = 4'd7;
  localparam logic [3:0] REQ_RESTART    = 4'd8;
  localparam logic [3:0] REQ_WOULD_FLOW = 4'd9;
  localparam logic [3:0] REQ_REMAINING  = 4'd10;

  // Error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [1:0] ERR_UNDERFLOW = 2'd2;

  // Bump modes
  localparam logic [1:0] BUMP_REGULAR = 2'd0;
  localparam logic [1:0] BUMP_HORIZ   = 2'd1;
  localparam logic [1:0] BUMP_VERT    = 2'd2;

  // Position modes
  localparam logic [1:0] POS_STATIC   = 2'd0;
  localparam logic [1:0] POS_RELATIVE = 2'd1;
  localparam logic [1:0] POS_ABSOLUTE = 2'd2;
  localparam logic [1:0] POS_FIXED    = 2'd3;

  // One stack record: node data plus the flow of its children
  typedef struct packed {
    logic signed [31:0] pos_minor;
    logic signed [31:0] pos_major;
    logic signed [31:0] high_minor;
    logic signed [31:0] high_major;
    logic signed [31:0] lim_minor;
    logic signed [31:0] lim_major;
    logic               lim_minor_ok;
    logic               lim_major_ok;
    logic               wrap_at_zero;
    logic [23:0]        cw;
    logic [23:0]        ch;
    logic               cw_ok;
    logic               ch_ok;
    logic signed [23:0] ml;
    logic signed [23:0] mr;
    logic signed [23:0] mt;
    logic signed [23:0] mb;
    logic               new_flow;
    logic [1:0]         bump;
    logic [1:0]         position;
  } rec_t;

  typedef struct packed {
    logic               flow_result;
    logic signed [31:0] box_left;
    logic signed [31:0] box_top;
    logic signed [31:0] box_right;
    logic signed [31:0] box_bottom;
    logic signed [31:0] old_position;
    logic signed [31:0] space_x;
    logic               space_x_given;
    logic signed [31:0] space_y;
    logic               space_y_given;
    logic               wraps;
    logic [1:0]         error;
  } res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EX1,
    S_EX2,
    S_EX3
  } state_t;

endpackage

// ===== design/bfle_ram.sv =====
module bfle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/box_flow_layout_engine.sv =====
// Flow layout engine: places nested boxes and words along horizontal lines.
//
// Input channel (in_valid / in_stall): one request per transfer. The block
// raises in_stall while it works on a request, so one request is in flight.
// Output channel (out_valid / out_stall): exactly one result per request,
// held in an output register; a stalled result holds its value, and the
// next request is accepted while the result still waits to be taken.
// Config channel (cfg_valid / cfg_ready): writes snap_boxes; always ready. The
// user must see that it is written only while the block is idle; the block does not enforce this.
//
// A request goes through the stack memory read at the transfer edge, then decode
// with size derivation, flow checks, then placement and write-back to the stack.
// A new request is taken only once the last request is through. The stack records
// live in two mirrored memories so the top and the parent record are read
// together. If the result register is still full and stalled, the last step
// waits.
//
// Reset (rst, synchronous) empties the stack, clears the restart flag and
// snap_boxes. The memories need no clearing: only pushed records are read.
module box_flow_layout_engine
  import bfle_pkg::*;
#(
  parameter int STACK_DEPTH   = 128,
  parameter int FRACTION_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         req_type,
  input  logic [23:0]        width,
  input  logic               width_given,
  input  logic [23:0]        height,
  input  logic               height_given,
  input  logic signed [23:0] margin_left,
  input  logic signed [23:0] margin_right,
  input  logic signed [23:0] margin_top,
  input  logic signed [23:0] margin_bottom,
  input  logic               new_flow_context,
  input  logic [1:0]         bump_mode,
  input  logic [1:0]         position_mode,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               flow_result,
  output logic signed [31:0] box_left,
  output logic signed [31:0] box_top,
  output logic signed [31:0] box_right,
  output logic signed [31:0] box_bottom,
  output logic signed [31:0] old_position,
  output logic signed [31:0] space_x,
  output logic               space_x_given,
  output logic signed [31:0] space_y,
  output logic               space_y_given,
  output logic               wraps,
  output logic [1:0]         error,
  // config channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int TW = $clog2(STACK_DEPTH + 1);
  localparam int RW = $bits(rec_t);
  localparam logic [31:0] FRAC_MASK = (32'd1 << FRACTION_BITS) - 32'd1;

  // ---------------------------------------------------------------------
  // Arithmetic helpers
  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sh07FFFFFFF) begin
      return 32'sh7FFFFFFF;
    end else if (v < 36'shF80000000) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [35:0] sx32(input logic signed [31:0] v);
    return 36'(v);
  endfunction

  function automatic logic signed [35:0] sx24(input logic signed [23:0] v);
    return 36'(v);
  endfunction

  function automatic logic signed [35:0] ux24(input logic [23:0] v);
    return $signed(36'(v));
  endfunction

  function automatic logic signed [31:0] round_up(input logic signed [31:0] v);
    logic [31:0] r;
    r = v & FRAC_MASK;
    if (r == 32'd0) begin
      return v;
    end
    return sat32(sx32(v) + $signed(36'(FRAC_MASK - r + 32'd1)));
  endfunction

  function automatic logic must_flow(input rec_t f, input logic signed [31:0] size);
    logic signed [31:0] s;
    logic on_new;
    logic over;
    s = sat32(sx32(f.pos_minor) + sx32(size));
    on_new = (f.pos_minor == 32'sd0);
    over = f.lim_minor_ok && (s > f.lim_minor);
    return (!on_new || f.wrap_at_zero) && over;
  endfunction

  function automatic rec_t new_line(input rec_t f);
    rec_t r;
    r = f;
    r.pos_major = f.high_major;
    if (f.pos_minor > f.high_minor) begin
      r.high_minor = f.pos_minor;
    end
    r.pos_minor = 32'sd0;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // State
  state_t         state, state_next;
  logic [TW-1:0]  top;
  logic           waiting;
  logic           snap;

  // latched request
  logic [3:0]         cur_req;
  logic [23:0]        cur_w, cur_h;
  logic               cur_wg, cur_hg;
  logic signed [23:0] cur_ml, cur_mr, cur_mt, cur_mb;
  logic               cur_nf;
  logic [1:0]         cur_bump, cur_pos;

  // memory ports
  rec_t           rd_top, rd_par;
  logic [RW-1:0]  rd_top_raw, rd_par_raw;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  rec_t           ram_wdata;
  logic [AW-1:0]  addr_top, addr_par;

  assign addr_top = AW'(top - TW'(1));
  assign addr_par = AW'(top - TW'(2));
  assign rd_top   = rec_t'(rd_top_raw);
  assign rd_par   = rec_t'(rd_par_raw);

  // Two mirrored copies: one read at the top record, one at its parent
  bfle_ram #(.WIDTH(RW), .DEPTH(STACK_DEPTH)) u_ram_top (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (RW'(ram_wdata)),
    .raddr (addr_top),
    .rdata (rd_top_raw)
  );

  bfle_ram #(.WIDTH(RW), .DEPTH(STACK_DEPTH)) u_ram_par (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (RW'(ram_wdata)),
    .raddr (addr_par),
    .rdata (rd_par_raw)
  );

  // ---------------------------------------------------------------------
  // Step 1: decode the request against the top records
  res_t           d_res;
  logic           d_we;
  logic [AW-1:0]  d_waddr;
  rec_t           d_wrec;
  logic [TW-1:0]  d_top;
  logic           d_wait_clr;
  logic           d_place;
  logic           d_pop;
  logic [AW-1:0]  d_paddr;
  rec_t           d_n, d_f;
  logic           d_inside;
  logic signed [31:0] d_cw, d_ch;

  always_comb begin
    rec_t t;
    rec_t nn;
    logic signed [31:0] b;
    d_res      = '0;
    d_we       = 1'b0;
    d_waddr    = addr_top;
    d_wrec     = rd_top;
    d_top      = top;
    d_wait_clr = 1'b0;
    d_place    = 1'b0;
    d_pop      = 1'b0;
    d_paddr    = addr_top;
    d_n        = rd_top;
    d_f        = rd_par;
    d_inside   = 1'b1;
    t          = rd_top;
    nn         = '0;
    b          = '0;

    if (cur_req == REQ_RESTART) begin
      d_wait_clr = 1'b1;
    end else if (cur_req > REQ_REMAINING) begin
      d_res = '0;
    end else if ((cur_req == REQ_BEGIN_DOC || cur_req == REQ_BEGIN_NODE ||
                  cur_req == REQ_WORD) && top >= TW'(STACK_DEPTH)) begin
      d_res.error = ERR_OVERFLOW;
    end else if (cur_req == REQ_END_NODE) begin
      if (top < TW'(2)) begin
        d_res.error = ERR_UNDERFLOW;
      end else begin
        d_place  = 1'b1;
        d_pop    = 1'b1;
        d_n      = rd_top;
        d_f      = rd_par;
        d_inside = !rd_par.new_flow;
        d_paddr  = addr_par;
      end
    end else if (cur_req == REQ_BEGIN_DOC) begin
      d_we       = 1'b1;
      d_waddr    = AW'(top);
      d_wrec     = '0;
      d_top      = top + TW'(1);
      d_wait_clr = 1'b1;
    end else if (top == TW'(0)) begin
      d_res.error = ERR_UNDERFLOW;
    end else begin
      case (cur_req)
        REQ_END_DOC: begin
          d_top = top - TW'(1);
        end
        REQ_BEGIN_NODE: begin
          nn.cw           = cur_w;
          nn.cw_ok        = cur_wg;
          nn.ch           = cur_h;
          nn.ch_ok        = cur_hg;
          nn.ml           = cur_ml;
          nn.mr           = cur_mr;
          nn.mt           = cur_mt;
          nn.mb           = cur_mb;
          nn.new_flow     = cur_nf;
          nn.bump         = cur_bump;
          nn.position     = cur_pos;
          nn.lim_minor    = $signed(32'(cur_w));
          nn.lim_minor_ok = cur_wg;
          nn.lim_major    = $signed(32'(cur_h));
          nn.lim_major_ok = cur_hg;
          if (!cur_nf && !cur_wg && t.lim_minor_ok) begin
            nn.lim_minor    = sat32(sx32(t.lim_minor) - sx32(t.pos_minor) -
                                    (sx24(cur_ml) + sx24(cur_mr)));
            nn.lim_minor_ok = 1'b1;
            if (t.pos_minor != 32'sd0 || t.wrap_at_zero) begin
              nn.wrap_at_zero = 1'b1;
            end
          end
          d_we    = 1'b1;
          d_waddr = AW'(top);
          d_wrec  = nn;
          d_top   = top + TW'(1);
        end
        REQ_WORD: begin
          // word acts as a pushed then ended node inside the top flow
          nn.cw       = cur_wg ? cur_w : 24'd0;
          nn.cw_ok    = 1'b1;
          nn.ch       = cur_hg ? cur_h : 24'd0;
          nn.ch_ok    = 1'b1;
          nn.new_flow = 1'b1;
          d_place     = 1'b1;
          d_n         = nn;
          d_f         = rd_top;
          d_inside    = 1'b1;
          d_paddr     = addr_top;
        end
        REQ_SPACE: begin
          d_res.old_position = t.pos_minor;
          t.pos_minor = sat32(sx32(t.pos_minor) + ux24(cur_w));
          d_we   = 1'b1;
          d_wrec = t;
        end
        REQ_NEWLINE: begin
          b = sat32(sx32(t.pos_major) + ux24(cur_h));
          if (b > t.high_major) begin
            t.high_major = b;
          end
          d_we   = 1'b1;
          d_wrec = t;
        end
        REQ_BREAK: begin
          d_we   = 1'b1;
          d_wrec = new_line(t);
        end
        REQ_WOULD_FLOW: begin
          d_res.wraps = must_flow(t, $signed(32'(cur_w)));
        end
        default: begin
          if (t.lim_minor_ok) begin
            d_res.space_x       = sat32(sx32(t.lim_minor) - sx32(t.pos_minor));
            d_res.space_x_given = 1'b1;
          end
          if (t.lim_major_ok) begin
            d_res.space_y       = sat32(sx32(t.lim_major) - sx32(t.pos_major));
            d_res.space_y_given = 1'b1;
          end
        end
      endcase
    end

    // content size: given, or taken from the node's own flow
    d_cw = $signed(32'(d_n.cw));
    if (!d_n.cw_ok) begin
      d_cw = (d_n.high_minor > d_n.pos_minor) ? d_n.high_minor : d_n.pos_minor;
      if (snap) begin
        d_cw = round_up(d_cw);
      end
    end
    d_ch = $signed(32'(d_n.ch));
    if (!d_n.ch_ok) begin
      d_ch = d_n.high_major;
      if (snap) begin
        d_ch = round_up(d_ch);
      end
    end
  end

  // step 1 results
  res_t           s_res;
  logic           s_we;
  logic [AW-1:0]  s_waddr;
  rec_t           s_wrec;
  logic [TW-1:0]  s_top;
  logic           s_wait_clr;
  logic           s_place;
  logic           s_pop;
  logic [AW-1:0]  s_paddr;
  rec_t           s_n, s_f;
  logic           s_inside;
  logic signed [31:0] s_cw, s_ch;

  // ---------------------------------------------------------------------
  // Step 2: margin box size and flow checks
  logic               e_abs_fix, e_do_h, e_do_v;
  logic signed [31:0] e_mbw, e_mbh, e_wff;
  logic               e_restart, e_nl;

  always_comb begin
    e_abs_fix = (s_n.position == POS_ABSOLUTE) || (s_n.position == POS_FIXED);
    e_do_v    = (s_n.bump == BUMP_REGULAR) || (s_n.bump == BUMP_VERT);
    e_do_h    = (s_n.bump == BUMP_REGULAR) || (s_n.bump == BUMP_HORIZ);
    e_mbw     = sat32(sx24(s_n.ml) + sx24(s_n.mr) + sx32(s_cw));
    e_mbh     = sat32(sx24(s_n.mt) + sx24(s_n.mb) + sx32(s_ch));
    e_wff     = e_do_h ? e_mbw : sat32(sx32(e_mbw) - sx24(s_n.ml) - sx24(s_n.mr));
    e_restart = !waiting && s_inside && !e_abs_fix && must_flow(s_f, s_cw);
    e_nl      = !waiting && !e_abs_fix && must_flow(s_f, e_wff);
  end

  logic               m_restart, m_nl, m_do_h, m_do_v;
  logic signed [31:0] m_mbw, m_mbh;

  // ---------------------------------------------------------------------
  // Step 3: placement in the parent flow
  rec_t               p_f;
  res_t               p_res;

  always_comb begin
    rec_t f;
    logic signed [31:0] left, tp, right, bottom, rpt, bpt;
    f      = m_nl ? new_line(s_f) : s_f;
    left   = f.pos_minor;
    tp     = f.pos_major;
    right  = sat32(sx32(f.pos_minor) + sx32(m_mbw));
    bottom = sat32(sx32(f.pos_major) + sx32(m_mbh));
    rpt    = right;
    if (!m_do_h) begin
      left  = sat32(sx32(left) - sx24(s_n.ml));
      right = sat32(sx32(right) - sx24(s_n.ml));
      rpt   = sat32(sx32(right) - sx24(s_n.mr));
    end
    bpt = bottom;
    if (!m_do_v) begin
      tp     = sat32(sx32(tp) - sx24(s_n.mt));
      bottom = sat32(sx32(bottom) - sx24(s_n.mt));
      bpt    = sat32(sx32(bottom) - sx24(s_n.mb));
    end
    if (s_n.position == POS_STATIC || s_n.position == POS_RELATIVE) begin
      f.pos_minor = rpt;
      if (bpt > f.high_major) begin
        f.high_major = bpt;
      end
    end
    p_f   = f;
    p_res = '0;
    if (m_restart) begin
      p_res.flow_result = 1'b1;
    end else begin
      p_res.box_left   = left;
      p_res.box_top    = tp;
      p_res.box_right  = right;
      p_res.box_bottom = bottom;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  logic go;
  res_t out_res;

  assign go = (state == S_EX3) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_EX1;
      S_EX1:   state_next = S_EX2;
      S_EX2:   state_next = S_EX3;
      S_EX3:   if (go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != S_IDLE);
    ram_we    = 1'b0;
    ram_waddr = s_waddr;
    ram_wdata = s_wrec;
    if (go) begin
      if (s_place) begin
        ram_we    = !m_restart;
        ram_waddr = s_paddr;
        ram_wdata = p_f;
      end else begin
        ram_we    = s_we;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      top       <= '0;
      waiting   <= 1'b0;
      snap      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        snap <= cfg_data;
      end
      if (go) begin
        out_valid <= 1'b1;
        if (s_place) begin
          top <= top - TW'(s_pop);
          if (m_restart) begin
            waiting <= 1'b1;
          end
        end else begin
          top <= s_top;
          if (s_wait_clr) begin
            waiting <= 1'b0;
          end
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cur_req  <= req_type;
      cur_w    <= width;
      cur_wg   <= width_given;
      cur_h    <= height;
      cur_hg   <= height_given;
      cur_ml   <= margin_left;
      cur_mr   <= margin_right;
      cur_mt   <= margin_top;
      cur_mb   <= margin_bottom;
      cur_nf   <= new_flow_context;
      cur_bump <= bump_mode;
      cur_pos  <= position_mode;
    end
    if (state == S_EX1) begin
      s_res      <= d_res;
      s_we       <= d_we;
      s_waddr    <= d_waddr;
      s_wrec     <= d_wrec;
      s_top      <= d_top;
      s_wait_clr <= d_wait_clr;
      s_place    <= d_place;
      s_pop      <= d_pop;
      s_paddr    <= d_paddr;
      s_n        <= d_n;
      s_f        <= d_f;
      s_inside   <= d_inside;
      s_cw       <= d_cw;
      s_ch       <= d_ch;
    end
    if (state == S_EX2) begin
      m_restart <= e_restart;
      m_nl      <= e_nl;
      m_do_h    <= e_do_h;
      m_do_v    <= e_do_v;
      m_mbw     <= e_mbw;
      m_mbh     <= e_mbh;
    end
    if (go) begin
      out_res <= s_place ? p_res : s_res;
    end
  end

  // result ports
  assign cfg_ready     = 1'b1;
  assign flow_result   = out_res.flow_result;
  assign box_left      = out_res.box_left;
  assign box_top       = out_res.box_top;
  assign box_right     = out_res.box_right;
  assign box_bottom    = out_res.box_bottom;
  assign old_position  = out_res.old_position;
  assign space_x       = out_res.space_x;
  assign space_x_given = out_res.space_x_given;
  assign space_y       = out_res.space_y;
  assign space_y_given = out_res.space_y_given;
  assign wraps         = out_res.wraps;
  assign error         = out_res.error;

endmodule
